FILE: rtl/irml_pkg.sv
// ----------------------------------------------------------------------------
// irml_pkg: shared types and constants of the infrared median linearizer
// Word layouts, field widths, action codes and the median-of-three helper.
// ----------------------------------------------------------------------------
package irml_pkg;

    localparam int NUM_CHANNELS_DEF = 4;
    localparam int TABLE_POINTS_DEF = 17;

    localparam int SENSOR_W = 2;
    localparam int SAMPLE_W = 10;
    localparam int PIDX_W   = 5;
    localparam int DIST_W   = 12;
    localparam int RING_LEN = 3;

    localparam int IN_TDATA_W  = 40;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 32;

    localparam int IN_SENSOR_LSB = 0;
    localparam int IN_SAMPLE_LSB = IN_SENSOR_LSB + SENSOR_W;
    localparam int IN_PIDX_LSB   = IN_SAMPLE_LSB + SAMPLE_W;
    localparam int IN_PADC_LSB   = IN_PIDX_LSB + PIDX_W;
    localparam int IN_PDIST_LSB  = IN_PADC_LSB + SAMPLE_W;
    localparam int OUT_USED_W    = SENSOR_W + SAMPLE_W + DIST_W + 1;

    localparam int DX_W   = SAMPLE_W + 1;
    localparam int DY_W   = DIST_W + 1;
    localparam int PROD_W = DY_W + DX_W;
    localparam int NUM_W  = PROD_W + 1;
    localparam int MAG_W  = NUM_W - 1;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_WRITE  = 1'b1;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [DIST_W-1:0]   dist_t;

    typedef struct packed {
        logic [1:0] ptr;
        sample_t    s2;
        sample_t    s1;
        sample_t    s0;
    } win_row_t;

    typedef struct packed {
        dist_t   distance;
        sample_t adc;
    } tab_entry_t;

    function automatic sample_t med3(input sample_t a, input sample_t b, input sample_t c);
        sample_t lo;
        sample_t hi;
        sample_t res;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (c < lo)
        begin
            res = lo;
        end
        else if (c > hi)
        begin
            res = hi;
        end
        else
        begin
            res = c;
        end
        return res;
    endfunction

endpackage

FILE: rtl/irml_divider.sv
// ----------------------------------------------------------------------------
// irml_divider: restoring divider for the interpolation quotient
// Produces one quotient bit per cycle; the caller guarantees that the
// quotient fits in DIST_W bits.
// ----------------------------------------------------------------------------
module irml_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [irml_pkg::MAG_W-1:0]    dividend,
    input  logic [irml_pkg::SAMPLE_W-1:0] divisor,
    output logic                          done,
    output logic [irml_pkg::DIST_W-1:0]   quotient
);
    import irml_pkg::*;

    localparam int CNT_W = $clog2(DIST_W + 1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [MAG_W-1:0] rem_reg, rem_next;
    logic [MAG_W-1:0] dv_reg, dv_next;
    dist_t            q_reg, q_next;
    logic [MAG_W:0]   sub;
    logic             ge;

    always_comb
    begin
        sub       = {1'b0, rem_reg} - {1'b0, dv_reg};
        ge        = ~sub[MAG_W];
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dv_next   = dv_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIST_W);
            rem_next  = dividend;
            dv_next   = MAG_W'(divisor) << (DIST_W - 1);
            q_next    = '0;
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            rem_next = ge ? sub[MAG_W-1:0] : rem_reg;
            q_next   = {q_reg[DIST_W-2:0], ge};
            dv_next  = dv_reg >> 1;
            cnt_next = cnt_reg - CNT_W'(1);
        end
        else if (busy_reg)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dv_reg  <= dv_next;
        q_reg   <= q_next;
    end

    assign done     = busy_reg && (cnt_reg == '0);
    assign quotient = q_reg;

endmodule

FILE: rtl/ir_median_interp_linearizer_unit.sv
// ----------------------------------------------------------------------------
// ir_median_interp_linearizer_unit: median-of-three filter and linearizer
// A sample word passes the window update, a table scan that reads one
// calibration point per cycle (1 to TABLE_POINTS-1 points), the difference
// and multiply states and, unless clamped early, the bit-serial divider;
// one word is in flight. A table write word is written as it is accepted.
// Reset clears the control state and the row valid bits, so every sample
// window reads as zero; the tables are not cleared.
// ----------------------------------------------------------------------------
module ir_median_interp_linearizer_unit #(
    parameter int NUM_CHANNELS = irml_pkg::NUM_CHANNELS_DEF,
    parameter int TABLE_POINTS = irml_pkg::TABLE_POINTS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // sensor, sample, point_index, point_adc, point_distance, zero pad
    input  logic [irml_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // action
    input  logic [irml_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // out_sensor, median_value, distance, clamped, zero pad
    output logic [irml_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import irml_pkg::*;

    localparam int CH_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int IDX_W     = $clog2(TABLE_POINTS);
    localparam int TAB_DEPTH = NUM_CHANNELS * (2 ** IDX_W);
    localparam int TAB_AW    = CH_W + IDX_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_POINTS - 1);

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_WIN  = 10'b0000000010,
        S_P0   = 10'b0000000100,
        S_SCAN = 10'b0000001000,
        S_DIFF = 10'b0000010000,
        S_MUL1 = 10'b0000100000,
        S_MUL2 = 10'b0001000000,
        S_PREP = 10'b0010000000,
        S_DIV  = 10'b0100000000,
        S_DONE = 10'b1000000000
    } state_t;

    logic [SENSOR_W-1:0] in_sensor;
    sample_t             in_sample;
    logic [PIDX_W-1:0]   in_pidx;
    sample_t             in_padc;
    dist_t               in_pdist;
    logic                in_action;
    logic                in_ch_ok;
    logic                in_pidx_ok;
    logic [CH_W-1:0]     in_ch;
    logic                accept;

    state_t state_reg, state_next;
    logic [CH_W-1:0]           ch_reg, ch_next;
    sample_t                   smp_reg, smp_next;
    sample_t                   med_reg, med_next;
    logic [IDX_W-1:0]          x_reg, x_next;
    tab_entry_t                prev_reg, prev_next;
    tab_entry_t                cur_reg, cur_next;
    logic signed [DX_W-1:0]    dx_reg, dx_next;
    logic signed [DY_W-1:0]    dy_reg, dy_next;
    logic signed [DX_W-1:0]    diff_reg, diff_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [NUM_W-1:0]   num_reg, num_next;
    logic                      neg_reg, neg_next;
    dist_t                     dist_reg, dist_next;
    logic                      flag_reg, flag_next;
    logic                      m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0]    m_tdata_reg, m_tdata_next;

    tab_entry_t        tab_mem [TAB_DEPTH];
    tab_entry_t        tab_rdata_reg;
    logic              tab_we;
    logic [TAB_AW-1:0] tab_waddr;
    logic [TAB_AW-1:0] tab_raddr;

    win_row_t          win_mem [NUM_CHANNELS];
    win_row_t          win_rdata_reg;
    logic [NUM_CHANNELS-1:0] win_vld_reg;
    logic              win_we;
    win_row_t          win_wdata;
    win_row_t          row_cur;
    logic [1:0]        wp;

    logic              div_start;
    logic              div_done;
    dist_t             div_q;
    logic [MAG_W-1:0]  mag;
    sample_t           dxm;
    logic              ovf;
    logic signed [DY_W-1:0] d0s;
    logic              out_free;

    assign in_sensor  = s_axis_tdata[IN_SENSOR_LSB +: SENSOR_W];
    assign in_sample  = s_axis_tdata[IN_SAMPLE_LSB +: SAMPLE_W];
    assign in_pidx    = s_axis_tdata[IN_PIDX_LSB +: PIDX_W];
    assign in_padc    = s_axis_tdata[IN_PADC_LSB +: SAMPLE_W];
    assign in_pdist   = s_axis_tdata[IN_PDIST_LSB +: DIST_W];
    assign in_action  = s_axis_tuser[0];
    assign in_ch_ok   = int'(in_sensor) < NUM_CHANNELS;
    assign in_pidx_ok = int'(in_pidx) < TABLE_POINTS;
    assign in_ch      = CH_W'(in_sensor);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign tab_we    = accept && (in_action == ACT_WRITE) && in_ch_ok && in_pidx_ok;
    assign tab_waddr = {in_ch, IDX_W'(in_pidx)};

    always_ff @(posedge clk)
    begin
        if (tab_we)
        begin
            tab_mem[tab_waddr] <= '{distance: in_pdist, adc: in_padc};
        end
        tab_rdata_reg <= tab_mem[tab_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (win_we)
        begin
            win_mem[ch_reg] <= win_wdata;
        end
        win_rdata_reg <= win_mem[in_ch];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_vld_reg <= '0;
        end
        else if (win_we)
        begin
            win_vld_reg[ch_reg] <= 1'b1;
        end
    end

    assign row_cur  = win_vld_reg[ch_reg] ? win_rdata_reg : '0;
    assign wp       = (row_cur.ptr > 2'd2) ? 2'd0 : row_cur.ptr;
    assign d0s      = $signed({1'b0, prev_reg.distance});
    assign mag      = num_reg[NUM_W-1] ? MAG_W'(-num_reg) : MAG_W'(num_reg);
    assign dxm      = dx_reg[DX_W-1] ? SAMPLE_W'(-dx_reg) : SAMPLE_W'(dx_reg);
    assign ovf      = mag >= MAG_W'({dxm, {DIST_W{1'b0}}});
    assign out_free = !m_tvalid_reg || m_axis_tready;

    always_comb
    begin
        state_next = state_reg;
        ch_next    = ch_reg;
        smp_next   = smp_reg;
        med_next   = med_reg;
        x_next     = x_reg;
        prev_next  = prev_reg;
        cur_next   = cur_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        diff_next  = diff_reg;
        prod_next  = prod_reg;
        num_next   = num_reg;
        neg_next   = neg_reg;
        dist_next  = dist_reg;
        flag_next  = flag_reg;
        tab_raddr  = {ch_reg, {IDX_W{1'b0}}};
        win_we     = 1'b0;
        win_wdata  = row_cur;
        div_start  = 1'b0;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_axis_tready;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (in_action == ACT_SAMPLE) && in_ch_ok)
                begin
                    ch_next    = in_ch;
                    smp_next   = in_sample;
                    state_next = S_WIN;
                end
            end
            S_WIN:
            begin
                win_wdata.ptr = (wp == 2'd2) ? 2'd0 : wp + 2'd1;
                case (wp)
                    2'd0:    win_wdata.s0 = smp_reg;
                    2'd1:    win_wdata.s1 = smp_reg;
                    default: win_wdata.s2 = smp_reg;
                endcase
                win_we     = 1'b1;
                med_next   = med3(win_wdata.s0, win_wdata.s1, win_wdata.s2);
                tab_raddr  = {ch_reg, {IDX_W{1'b0}}};
                state_next = S_P0;
            end
            S_P0:
            begin
                prev_next  = tab_rdata_reg;
                x_next     = IDX_W'(1);
                tab_raddr  = {ch_reg, IDX_W'(1)};
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                tab_raddr = {ch_reg, x_reg + IDX_W'(1)};
                if ((x_reg == LAST_IDX) || (tab_rdata_reg.adc < med_reg))
                begin
                    cur_next   = tab_rdata_reg;
                    state_next = S_DIFF;
                end
                else
                begin
                    prev_next = tab_rdata_reg;
                    x_next    = x_reg + IDX_W'(1);
                end
            end
            S_DIFF:
            begin
                dx_next    = $signed({1'b0, cur_reg.adc}) - $signed({1'b0, prev_reg.adc});
                dy_next    = $signed({1'b0, cur_reg.distance})
                             - $signed({1'b0, prev_reg.distance});
                diff_next  = $signed({1'b0, med_reg}) - $signed({1'b0, prev_reg.adc});
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                prod_next  = PROD_W'(dy_reg) * PROD_W'(diff_reg);
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                num_next   = NUM_W'(prod_reg) + NUM_W'(d0s) * NUM_W'(dx_reg);
                state_next = S_PREP;
            end
            S_PREP:
            begin
                neg_next = num_reg[NUM_W-1] ^ dx_reg[DX_W-1];
                if (dx_reg == '0)
                begin
                    dist_next  = DIST_MAX;
                    flag_next  = 1'b1;
                    state_next = S_DONE;
                end
                else if (ovf)
                begin
                    dist_next  = (num_reg[NUM_W-1] ^ dx_reg[DX_W-1]) ? '0 : DIST_MAX;
                    flag_next  = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (neg_reg && (div_q != '0))
                    begin
                        dist_next = '0;
                        flag_next = 1'b1;
                    end
                    else
                    begin
                        dist_next = div_q;
                        flag_next = 1'b0;
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    m_tdata_next = {{(OUT_TDATA_W - OUT_USED_W){1'b0}}, flag_reg, dist_reg,
                                    med_reg, SENSOR_W'(ch_reg)};
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    irml_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mag),
        .divisor  (dxm),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg      <= ch_next;
        smp_reg     <= smp_next;
        med_reg     <= med_next;
        x_reg       <= x_next;
        prev_reg    <= prev_next;
        cur_reg     <= cur_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        diff_reg    <= diff_next;
        prod_reg    <= prod_next;
        num_reg     <= num_next;
        neg_reg     <= neg_next;
        dist_reg    <= dist_next;
        flag_reg    <= flag_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

    a_sample_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_action == ACT_SAMPLE) && in_ch_ok) |=> (state_reg == S_WIN))
        else $error("A sample word did not start the window update.");

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> ((x_reg != '0) && (x_reg <= LAST_IDX)))
        else $error("The table scan left the calibration range.");

    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("The divider finished outside the divide state.");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("A result word appeared without a finished computation.");

endmodule
